// ===== design/mvac_pkg.sv =====
// shared types, constants, rounding and saturation helpers for the multirotor
// velocity and attitude controller; no dependencies
`default_nettype none
package mvac_pkg;

	localparam int unsigned NUM_LANES = 3;
	localparam logic [19:0] GRAVITY_Q16 = 20'd642908;
	localparam logic [18:0] LEVEL_GAIN = 19'd5;
	localparam int unsigned DIV_STEPS = 24;
	localparam int unsigned ROOT_STEPS = 31;

	typedef enum logic [2:0] {
		REG_VELOCITY_GAIN = 3'd0,
		REG_YAW_GAIN      = 3'd1,
		REG_FORCE_LIMIT   = 3'd2,
		REG_BODY_MASS     = 3'd3,
		REG_YAW_INERTIA   = 3'd4,
		REG_TIMEOUT       = 3'd5
	} reg_index_t;

	typedef enum logic [2:0] {
		LOP_NONE,
		LOP_MUL1,
		LOP_MUL2,
		LOP_SHIFT,
		LOP_SQ,
		LOP_PROD,
		LOP_DIVINIT,
		LOP_DIV
	} lane_op_t;

	typedef struct packed {
		lane_op_t    op;
		logic [2:0]  shift;
		logic [15:0] mass;
		logic [15:0] vg;
		logic [22:0] fl;
		logic [30:0] len;
	} lane_ctl_t;

	typedef struct packed {
		logic signed [35:0] f;
		logic [34:0]        mag;
		logic [59:0]        sq;
		logic [23:0]        q;
	} lane_stat_t;

	// round to nearest, ties away from zero
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
		input logic [5:0] sh);
		logic [63:0] m;
		logic [63:0] r;
		begin
			m = v[63] ? 64'(-v) : 64'(v);
			r = (m + (64'd1 << (sh - 6'd1))) >> sh;
			rnd_shift = v[63] ? -$signed(r) : $signed(r);
		end
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		begin
			if (v > 64'sd8388607) begin
				sat24 = 24'sh7FFFFF;
			end else if (v < -64'sd8388608) begin
				sat24 = 24'sh800000;
			end else begin
				sat24 = 24'(v);
			end
		end
	endfunction

endpackage
`default_nettype wire

// ===== design/mvac_lane.sv =====
// one force axis: error scaling, magnitude, square and rescale divider
// depends on mvac_pkg
`default_nettype none
module mvac_lane (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mvac_pkg::lane_ctl_t ctl,
	input  wire logic signed [16:0]  err,
	output mvac_pkg::lane_stat_t     stat
);
	import mvac_pkg::*;

	logic signed [33:0] p1_q;
	logic signed [35:0] f_q;
	logic [29:0]        m_q;
	logic [59:0]        sq_q;
	logic [53:0]        num_q;
	logic [30:0]        rem_q;
	logic [23:0]        q_q;
	logic signed [50:0] p2;
	logic [34:0]        mag;
	logic [31:0]        trial;
	logic               ge;

	assign p2 = p1_q * $signed({1'b0, ctl.vg});
	assign mag = f_q[35] ? 35'(-f_q) : 35'(f_q);
	assign trial = {rem_q, q_q[23]};
	assign ge = trial >= {1'b0, ctl.len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
		end else begin
			case (ctl.op)
				LOP_DIVINIT: q_q <= num_q[23:0];
				LOP_DIV:     q_q <= {q_q[22:0], ge};
				default:     q_q <= q_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			LOP_MUL1:    p1_q <= err * $signed({1'b0, ctl.mass});
			LOP_MUL2:    f_q <= 36'(rnd_shift(64'(p2), 6'd16));
			LOP_SHIFT:   m_q <= 30'(mag >> ctl.shift);
			LOP_SQ:      sq_q <= m_q * m_q;
			LOP_PROD:    num_q <= 54'(m_q) * 54'(ctl.fl) + 54'(ctl.len >> 1);
			LOP_DIVINIT: rem_q <= 31'(num_q[53:24]);
			LOP_DIV:     rem_q <= ge ? 31'(trial - {1'b0, ctl.len}) : trial[30:0];
			default: begin
			end
		endcase
	end

	assign stat.f = f_q;
	assign stat.mag = mag;
	assign stat.sq = sq_q;
	assign stat.q = q_q;

endmodule
`default_nettype wire

// ===== design/mvac_isqrt.sv =====
// iterative integer square root, two radicand bits per cycle
// depends on mvac_pkg
`default_nettype none
module mvac_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [61:0] radicand,
	output logic [30:0]      root,
	output logic             done
);
	import mvac_pkg::*;

	logic [61:0] rad_q;
	logic [32:0] rem_q;
	logic [30:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] t;
	logic [34:0] trial;
	logic        ge;

	assign t = {rem_q, rad_q[61:60]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge = t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 5'(ROOT_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(ROOT_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[59:0], 2'b00};
			rem_q <= ge ? 33'(t - trial) : 33'(t);
			root_q <= {root_q[29:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ===== design/multirotor_velocity_attitude_control.sv =====
// A tick whose force stays inside force_limit goes from transfer to result
// without the rescale; when it is rescaled, the 31-step square root of the
// squared force length and then the 24-step dividers of the three axis lanes,
// which run side by side, come before the result. A command gives no result
// and leaves the sequencer idle. One item is worked on at a time; a finished result
// waits in the output register while the next item is taken.
// depends on mvac_pkg, mvac_lane, mvac_isqrt
`default_nettype none
module multirotor_velocity_attitude_control (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [22:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               operation,
	input  wire logic [31:0]        time_ms,
	input  wire logic signed [15:0] lin_x,
	input  wire logic signed [15:0] lin_y,
	input  wire logic signed [15:0] lin_z,
	input  wire logic signed [15:0] rate_x,
	input  wire logic signed [15:0] rate_y,
	input  wire logic signed [15:0] rate_z,
	input  wire logic signed [15:0] roll_angle,
	input  wire logic signed [15:0] pitch_angle,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [23:0]      force_x,
	output logic signed [23:0]      force_y,
	output logic signed [23:0]      force_z,
	output logic signed [23:0]      torque_x,
	output logic signed [23:0]      torque_y,
	output logic signed [23:0]      yaw_torque,
	output logic                    command_stale
);
	import mvac_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_SHIFT, S_SQ, S_CHK, S_ROOT, S_PROD, S_DIVI, S_DIV, S_OUT
	} state_t;

	state_t state_q;

	logic [15:0] vg_q, yg_q, mass_q, inertia_q, timeout_q;
	logic [22:0] fl_q;
	logic signed [15:0] tgt_x_q, tgt_y_q, tgt_z_q, tgt_yaw_q;
	logic [31:0] cmd_time_q;

	logic signed [16:0] err_q [NUM_LANES];
	logic signed [16:0] ez_q;
	logic signed [15:0] rx_q, ry_q, ang_r_q, ang_p_q;
	logic               stale_q;
	logic signed [33:0] tz1_q;
	logic signed [35:0] tz_q, tx_q, ty_q;
	logic signed [21:0] grav_q;
	logic [2:0]         shift_q;
	logic               clamp_q;
	logic [30:0]        len_q;
	logic [4:0]         cnt_q;

	lane_ctl_t  ctl;
	lane_stat_t stat [NUM_LANES];

	logic        accept;
	logic        stale;
	logic [31:0] age;
	logic [34:0] maxm;
	logic [2:0]  shift;
	logic [61:0] sum;
	logic [45:0] fl_sq;
	logic        clamp;
	logic        root_start;
	logic [30:0] root;
	logic        root_done;
	logic signed [50:0] tz2;
	logic [18:0] g5;
	logic signed [20:0] lev_r, lev_p;
	logic signed [40:0] prod_r, prod_p;
	logic [35:0] grav_raw;
	logic signed [35:0] fsel [NUM_LANES];

	assign in_stall = state_q != S_IDLE;
	assign accept = in_valid && !in_stall;
	assign age = time_ms - cmd_time_q;
	assign stale = age > {16'b0, timeout_q};

	assign maxm = (stat[0].mag > stat[1].mag)
		? ((stat[0].mag > stat[2].mag) ? stat[0].mag : stat[2].mag)
		: ((stat[1].mag > stat[2].mag) ? stat[1].mag : stat[2].mag);
	always_comb begin
		if (maxm[34:30] == 5'b0) begin
			shift = 3'd0;
		end else if (maxm[34:31] == 4'b0) begin
			shift = 3'd1;
		end else if (maxm[34:32] == 3'b0) begin
			shift = 3'd2;
		end else if (maxm[34:33] == 2'b0) begin
			shift = 3'd3;
		end else if (!maxm[34]) begin
			shift = 3'd4;
		end else begin
			shift = 3'd5;
		end
	end

	assign sum = 62'(stat[0].sq) + 62'(stat[1].sq) + 62'(stat[2].sq);
	assign fl_sq = 46'(fl_q) * 46'(fl_q);
	assign clamp = (shift_q != 3'd0) || (sum > {16'b0, fl_sq});
	assign root_start = (state_q == S_CHK) && clamp;

	assign tz2 = tz1_q * $signed({1'b0, yg_q});
	assign g5 = 19'(mass_q) * LEVEL_GAIN;
	assign lev_r = 21'(ang_r_q) + (21'(rx_q) <<< 4);
	assign lev_p = 21'(ang_p_q) + (21'(ry_q) <<< 4);
	assign prod_r = $signed({1'b0, g5}) * lev_r;
	assign prod_p = $signed({1'b0, g5}) * lev_p;
	assign grav_raw = 36'(mass_q) * 36'(GRAVITY_Q16);

	always_comb begin
		ctl.shift = shift;
		ctl.mass = mass_q;
		ctl.vg = vg_q;
		ctl.fl = fl_q;
		ctl.len = len_q;
		unique case (state_q)
			S_MUL1:  ctl.op = LOP_MUL1;
			S_MUL2:  ctl.op = LOP_MUL2;
			S_SHIFT: ctl.op = LOP_SHIFT;
			S_SQ:    ctl.op = LOP_SQ;
			S_PROD:  ctl.op = LOP_PROD;
			S_DIVI:  ctl.op = LOP_DIVINIT;
			S_DIV:   ctl.op = LOP_DIV;
			default: ctl.op = LOP_NONE;
		endcase
	end

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		mvac_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.err    (err_q[i]),
			.stat   (stat[i])
		);
		assign fsel[i] = clamp_q
			? (stat[i].f[35] ? -$signed({12'b0, stat[i].q}) : $signed({12'b0, stat[i].q}))
			: stat[i].f;
	end

	mvac_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sum),
		.root     (root),
		.done     (root_done)
	);

	// configuration and command state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vg_q <= 16'd1280;
			yg_q <= 16'd768;
			fl_q <= 23'd7680;
			mass_q <= 16'd256;
			inertia_q <= 16'd655;
			timeout_q <= 16'd500;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			tgt_z_q <= '0;
			tgt_yaw_q <= '0;
			cmd_time_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_VELOCITY_GAIN: vg_q <= cfg_data[15:0];
					REG_YAW_GAIN:      yg_q <= cfg_data[15:0];
					REG_FORCE_LIMIT:   fl_q <= cfg_data;
					REG_BODY_MASS:     mass_q <= cfg_data[15:0];
					REG_YAW_INERTIA:   inertia_q <= cfg_data[15:0];
					REG_TIMEOUT:       timeout_q <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			if (accept && !operation) begin
				tgt_x_q <= lin_x;
				tgt_y_q <= lin_y;
				tgt_z_q <= lin_z;
				tgt_yaw_q <= rate_z;
				cmd_time_q <= time_ms;
			end else if (accept && stale) begin
				tgt_x_q <= '0;
				tgt_y_q <= '0;
				tgt_z_q <= '0;
				tgt_yaw_q <= '0;
			end
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && operation) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_SHIFT;
				S_SHIFT: state_q <= S_SQ;
				S_SQ:    state_q <= S_CHK;
				S_CHK:   state_q <= clamp ? S_ROOT : S_OUT;
				S_ROOT: begin
					if (root_done) begin
						state_q <= S_PROD;
					end
				end
				S_PROD:  state_q <= S_DIVI;
				S_DIVI: begin
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(DIV_STEPS - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// tick datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q[0] <= (stale ? 17'sd0 : 17'(tgt_x_q)) - 17'(lin_x);
			err_q[1] <= (stale ? 17'sd0 : 17'(tgt_y_q)) - 17'(lin_y);
			err_q[2] <= (stale ? 17'sd0 : 17'(tgt_z_q)) - 17'(lin_z);
			ez_q <= (stale ? 17'sd0 : 17'(tgt_yaw_q)) - 17'(rate_z);
			rx_q <= rate_x;
			ry_q <= rate_y;
			ang_r_q <= roll_angle;
			ang_p_q <= pitch_angle;
			stale_q <= stale;
		end
		if (state_q == S_MUL1) begin
			tz1_q <= ez_q * $signed({1'b0, inertia_q});
			grav_q <= $signed({1'b0, 21'((grav_raw + 36'd32768) >> 16)});
			tx_q <= 36'(rnd_shift(-64'(prod_r), 6'd13));
			ty_q <= 36'(rnd_shift(-64'(prod_p), 6'd13));
		end
		if (state_q == S_MUL2) begin
			tz_q <= 36'(rnd_shift(64'(tz2), 6'd24));
		end
		if (state_q == S_SHIFT) begin
			shift_q <= shift;
		end
		if (state_q == S_CHK) begin
			clamp_q <= clamp;
		end
		if (state_q == S_ROOT && root_done) begin
			len_q <= root;
		end
		if (state_q == S_OUT && (!out_valid || !out_stall)) begin
			force_x <= sat24(64'(fsel[0]));
			force_y <= sat24(64'(fsel[1]));
			force_z <= sat24(64'(fsel[2]) + 64'(grav_q));
			torque_x <= sat24(64'(tx_q));
			torque_y <= sat24(64'(ty_q));
			yaw_torque <= sat24(64'(tz_q));
			command_stale <= stale_q;
		end
	end

endmodule
`default_nettype wire

// ===== bench/multirotor_velocity_attitude_control_test.sv =====
// self-checking bench for multirotor_velocity_attitude_control: directed table then
// random commands and ticks, checked against an in-bench fixed point predictor
// depends on mvac_pkg and the controller rtl
`timescale 1ns / 1ps
module multirotor_velocity_attitude_control_test;
	import mvac_pkg::*;

	localparam logic OP_COMMAND = 1'b0;
	localparam logic OP_TICK = 1'b1;
	localparam logic [2:0] REG_UNUSED = 3'd6;
	localparam int SETTLE = 80;
	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 700;

	typedef struct packed {
		logic op;
		logic [31:0] tms;
		logic signed [15:0] lx, ly, lz, rx, ry, rz, roll, pitch;
	} item_t;

	typedef struct packed {
		logic signed [23:0] fx, fy, fz, tx, ty, tz;
		logic stale;
	} control_t;

	typedef struct packed {
		item_t it;
		logic typed;
		control_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [22:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	item_t stim = '0;
	control_t got;

	control_t pending[$];
	row_t table_rows[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_pct = 0;
	int recv_pct = 0;
	logic [31:0] now_ms = '0;

	// predictor copy of registers and state
	logic [15:0] k_vel, k_yaw, k_mass, k_inertia, k_timeout;
	logic [22:0] k_limit;
	logic [15:0] tgt_vx, tgt_vy, tgt_vz, tgt_yaw;
	logic [31:0] cmd_ms;

	always #5 clk = ~clk;

	multirotor_velocity_attitude_control uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(stim.op), .time_ms(stim.tms),
		.lin_x(stim.lx), .lin_y(stim.ly), .lin_z(stim.lz),
		.rate_x(stim.rx), .rate_y(stim.ry), .rate_z(stim.rz),
		.roll_angle(stim.roll), .pitch_angle(stim.pitch),
		.out_valid(out_valid), .out_stall(out_stall),
		.force_x(got.fx), .force_y(got.fy), .force_z(got.fz),
		.torque_x(got.tx), .torque_y(got.ty), .yaw_torque(got.tz),
		.command_stale(got.stale)
	);

	function automatic longint round_shift(longint v, int sh);
		longint unsigned m;
		begin
			m = (v < 0) ? longint'(-v) : longint'(v);
			m = (m + (64'd1 << (sh - 1))) >> sh;
			return (v < 0) ? -longint'(m) : longint'(m);
		end
	endfunction

	function automatic logic signed [23:0] clip24(longint v);
		begin
			if (v > 64'sd8388607) return 24'sh7FFFFF;
			if (v < -64'sd8388608) return 24'sh800000;
			return v[23:0];
		end
	endfunction

	function automatic longint unsigned root64(longint unsigned x);
		longint unsigned r, b;
		begin
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		end
	endfunction

	function automatic void reset_model();
		k_vel = 16'd1280;
		k_yaw = 16'd768;
		k_limit = 23'd7680;
		k_mass = 16'd256;
		k_inertia = 16'd655;
		k_timeout = 16'd500;
		{tgt_vx, tgt_vy, tgt_vz, tgt_yaw} = '0;
		cmd_ms = '0;
	endfunction

	// returns 1 when the item yields a control result
	function automatic bit predict_control(item_t it, output control_t r);
		longint f[3], tgt[3], meas[3], grav, tz, tx, ty;
		longint unsigned m[3], maxm, sum, len, q, lim;
		int s;
		begin
			r = '0;
			if (it.op == OP_COMMAND) begin
				tgt_vx = it.lx;
				tgt_vy = it.ly;
				tgt_vz = it.lz;
				tgt_yaw = it.rz;
				cmd_ms = it.tms;
				return 0;
			end
			if (32'(it.tms - cmd_ms) > {16'd0, k_timeout}) begin
				{tgt_vx, tgt_vy, tgt_vz, tgt_yaw} = '0;
				r.stale = 1'b1;
			end
			tgt[0] = longint'($signed(tgt_vx));
			tgt[1] = longint'($signed(tgt_vy));
			tgt[2] = longint'($signed(tgt_vz));
			meas[0] = longint'($signed(it.lx));
			meas[1] = longint'($signed(it.ly));
			meas[2] = longint'($signed(it.lz));
			maxm = 0;
			for (int i = 0; i < 3; i++) begin
				f[i] = round_shift((tgt[i] - meas[i]) * longint'(k_mass) * longint'(k_vel), 16);
				m[i] = (f[i] < 0) ? longint'(-f[i]) : longint'(f[i]);
				if (m[i] > maxm) maxm = m[i];
			end
			s = 0;
			while ((maxm >> s) >= (64'd1 << 30)) s++;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				m[i] = m[i] >> s;
				sum += m[i] * m[i];
			end
			lim = longint'(k_limit);
			if (!(s == 0 && sum <= lim * lim)) begin
				len = root64(sum);
				for (int i = 0; i < 3; i++) begin
					q = (len != 0) ? (m[i] * lim + len / 2) / len : 0;
					f[i] = (f[i] < 0) ? -longint'(q) : longint'(q);
				end
			end
			grav = round_shift(longint'(k_mass) * 64'sd642908, 16);
			f[2] += grav;
			tz = round_shift((longint'($signed(tgt_yaw)) - longint'($signed(it.rz)))
				* longint'(k_inertia) * longint'(k_yaw), 24);
			tx = round_shift(-(5 * longint'(k_mass)) * (longint'($signed(it.roll))
				+ 16 * longint'($signed(it.rx))), 13);
			ty = round_shift(-(5 * longint'(k_mass)) * (longint'($signed(it.pitch))
				+ 16 * longint'($signed(it.ry))), 13);
			r.fx = clip24(f[0]);
			r.fy = clip24(f[1]);
			r.fz = clip24(f[2]);
			r.tx = clip24(tx);
			r.ty = clip24(ty);
			r.tz = clip24(tz);
			return 1;
		end
	endfunction

	// waits for every result, lets the block settle, then writes all registers
	task automatic set_regs(logic [15:0] vg, logic [15:0] yg, logic [22:0] fl,
		logic [15:0] mass, logic [15:0] inertia, logic [15:0] tmo);
		begin
			while (pending.size() != 0) @(posedge clk);
			repeat (SETTLE) @(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= REG_VELOCITY_GAIN; cfg_data <= {7'd0, vg}; @(posedge clk);
			cfg_index <= REG_YAW_GAIN; cfg_data <= {7'd0, yg}; @(posedge clk);
			cfg_index <= REG_FORCE_LIMIT; cfg_data <= fl; @(posedge clk);
			cfg_index <= REG_BODY_MASS; cfg_data <= {7'd0, mass}; @(posedge clk);
			cfg_index <= REG_YAW_INERTIA; cfg_data <= {7'd0, inertia}; @(posedge clk);
			cfg_index <= REG_TIMEOUT; cfg_data <= {7'd0, tmo}; @(posedge clk);
			// index past the register list must be ignored
			cfg_index <= REG_UNUSED; cfg_data <= 23'(($urandom)); @(posedge clk);
			cfg_we <= 1'b0;
			k_vel = vg;
			k_yaw = yg;
			k_limit = fl;
			k_mass = mass;
			k_inertia = inertia;
			k_timeout = tmo;
		end
	endtask

	task automatic send(item_t it, logic typed, control_t want);
		control_t r;
		begin
			if ($urandom_range(99) < send_pct) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			in_valid <= 1'b1;
			stim <= it;
			do @(posedge clk); while (in_stall);
			if (predict_control(it, r)) pending.push_back(typed ? want : r);
		end
	endtask

	function automatic logic [15:0] pick_vel();
		if ($urandom_range(3) == 0) return 16'($urandom);
		return 16'($urandom_range(2047)) - 16'd1024;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int pick;
		begin
			pick = $urandom_range(99);
			if (pick < 80) now_ms = now_ms + $urandom_range(300);
			else if (pick < 90) now_ms = $urandom;
			it.op = ($urandom_range(99) < 25) ? OP_COMMAND : OP_TICK;
			it.tms = now_ms;
			it.lx = pick_vel();
			it.ly = pick_vel();
			it.lz = pick_vel();
			it.rx = pick_vel();
			it.ry = pick_vel();
			it.rz = pick_vel();
			it.roll = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(4095)) - 16'd2048;
			it.pitch = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(4095)) - 16'd2048;
			return it;
		end
	endfunction

	function automatic void add_row(logic op, logic [31:0] tms, logic [15:0] lx, logic [15:0] ly,
		logic [15:0] lz, logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
		logic [15:0] roll, logic [15:0] pitch, logic typed, control_t want);
		row_t r;
		r.it = {op, tms, lx, ly, lz, rx, ry, rz, roll, pitch};
		r.typed = typed;
		r.want = want;
		table_rows.push_back(r);
	endfunction

	task automatic report(string name, longint e, longint a);
		if (e != a) $display("%0t %s expected %0d actual %0d", $realtime, name, e, a);
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				$display("%0t unexpected result transfer", $realtime);
				errors++;
			end else begin
				if (got !== pending[0]) begin
					errors++;
					report("force_x", pending[0].fx, got.fx);
					report("force_y", pending[0].fy, got.fy);
					report("force_z", pending[0].fz, got.fz);
					report("torque_x", pending[0].tx, got.tx);
					report("torque_y", pending[0].ty, got.ty);
					report("yaw_torque", pending[0].tz, got.tz);
					report("command_stale", pending[0].stale, got.stale);
				end
				void'(pending.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		control_t z, stale_zero;
		reset_model();
		z = '0;
		z.fz = 24'sd2511;
		stale_zero = z;
		stale_zero.stale = 1'b1;
		add_row(OP_TICK, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd0, 1'b1, z);
		add_row(OP_TICK, 32'd501, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd0, 1'b1, stale_zero);
		add_row(OP_COMMAND, 32'd1000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h1234, 16'h4321,
			16'h7FFF, 16'h5555, 16'hAAAA, 1'b0, z);
		add_row(OP_TICK, 32'd1000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
			16'h8000, 16'h8000, 16'h8000, 1'b0, z);
		add_row(OP_TICK, 32'd1500, 16'h0100, 16'h0000, 16'hFF00, 16'h8000, 16'h8000,
			16'h0000, 16'h7FFF, 16'h7FFF, 1'b0, z);
		add_row(OP_TICK, 32'd1501, 16'd0, 16'd0, 16'd0, 16'h0010, 16'hFFF0, 16'h0100,
			16'h2000, 16'hE000, 1'b0, z);
		add_row(OP_COMMAND, 32'hFFFF_FF00, 16'h0200, 16'h0000, 16'hFE00, 16'd0, 16'd0,
			16'hFF00, 16'd0, 16'd0, 1'b0, z);
		add_row(OP_TICK, 32'h0000_0010, 16'h0100, 16'h0080, 16'hFF80, 16'h0040, 16'hFFC0,
			16'h0080, 16'h0400, 16'hFC00, 1'b0, z);
		add_row(OP_TICK, 32'h0000_0020, 16'h0200, 16'h0000, 16'hFE00, 16'd0, 16'd0,
			16'hFF00, 16'd0, 16'd0, 1'b0, z);
		add_row(OP_TICK, 32'hFFFF_FFFF, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
			16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, z);
		add_row(OP_COMMAND, 32'hFFFF_FFFF, 16'h0400, 16'hFC00, 16'h0400, 16'd0, 16'd0,
			16'h0400, 16'd0, 16'd0, 1'b0, z);
		add_row(OP_TICK, 32'hFFFF_FFFF, 16'hFC00, 16'h0400, 16'hFC00, 16'h0001, 16'hFFFF,
			16'hFC00, 16'h0001, 16'hFFFF, 1'b0, z);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pct = 9;
		recv_pct = 72;
		foreach (table_rows[i]) send(table_rows[i].it, table_rows[i].typed, table_rows[i].want);
		in_valid <= 1'b0;

		// largest gains, zero force limit, zero mass
		set_regs(16'hFFFF, 16'hFFFF, 23'd0, 16'd0, 16'hFFFF, 16'hFFFF);
		for (int i = 0; i < 8; i++) send(random_item(), 1'b0, '0);
		in_valid <= 1'b0;
		set_regs(16'd1280, 16'd768, 23'd7680, 16'd256, 16'd655, 16'd500);
		for (int i = 0; i < RANDOM_ITEMS / 3; i++) send(random_item(), 1'b0, '0);
		in_valid <= 1'b0;

		send_pct = 72;
		recv_pct = 9;
		set_regs(16'hFFFF, 16'hFFFF, 23'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		for (int i = 0; i < RANDOM_ITEMS / 6; i++) send(random_item(), 1'b0, '0);
		in_valid <= 1'b0;
		set_regs(16'd0, 16'd0, 23'd0, 16'd1, 16'd0, 16'd0);
		for (int i = 0; i < RANDOM_ITEMS / 6; i++) send(random_item(), 1'b0, '0);
		in_valid <= 1'b0;

		send_pct = 0;
		recv_pct = 0;
		set_regs(16'($urandom_range(2560)), 16'($urandom), 23'($urandom_range(20000)),
			16'($urandom_range(1, 1024)), 16'($urandom), 16'($urandom_range(1000)));
		for (int i = 0; i < RANDOM_ITEMS / 3; i++) send(random_item(), 1'b0, '0);
		in_valid <= 1'b0;

		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
